// ----- rtl/dtf_pkg.sv -----
// Shared types, character codes and arithmetic constants for the decimal text
// to fixed-point converter. Depends on nothing; every other file imports it.
package dtf_pkg;

    // Character codes of interest.
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Integer part: 15 bits, saturating at its largest value.
    localparam int          INT_W   = 15;
    localparam logic [14:0] INT_MAX = 15'h7FFF;

    // Fraction digits kept, and the counter that tracks them.
    localparam int MAX_FRAC_DIGITS = 6;
    localparam int DIGITS_W        = $clog2(MAX_FRAC_DIGITS + 1);

    // The fraction is held normalised to six decimal places, so the final
    // scaling always divides by one million whatever the digit count.
    localparam int FRAC_W = 20;

    // Output format: signed Q15.16.
    localparam int VALUE_W  = 32;
    localparam int FRAC_Q_W = 16;

    // floor(f * 2^16 / 10^6) = (f * RECIP_MULT) >> RECIP_SHIFT for f < 2^20.
    localparam int          RECIP_W     = 31;
    localparam logic [30:0] RECIP_MULT  = 31'd1125899907;
    localparam int          RECIP_SHIFT = 34;
    localparam int          PROD_W      = FRAC_W + RECIP_W;

    // Snapshot of the accumulated number at the end of a text.
    typedef struct packed {
        logic [INT_W-1:0]  int_part;
        logic [FRAC_W-1:0] frac_norm;
        logic              minus;
        logic              saturated;
    } t_snap;

    // Place value of the next fraction digit, in millionths.
    function automatic logic [FRAC_W-1:0] frac_weight(input logic [DIGITS_W-1:0] idx);
        logic [FRAC_W-1:0] w;
        unique case (idx)
            DIGITS_W'(0): w = FRAC_W'(100000);
            DIGITS_W'(1): w = FRAC_W'(10000);
            DIGITS_W'(2): w = FRAC_W'(1000);
            DIGITS_W'(3): w = FRAC_W'(100);
            DIGITS_W'(4): w = FRAC_W'(10);
            DIGITS_W'(5): w = FRAC_W'(1);
            default:      w = '0;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/decimal_text_to_fixed.sv -----
// Top level of the decimal text to fixed-point converter.
// Depends on dtf_pkg, dtf_accum and dtf_scale.
//
// This block reads a decimal number as ASCII text, one character per input
// beat, and returns it as a signed Q15.16 value. A minus sign anywhere in the
// text makes the result negative, the first decimal point sends later digits
// to the fraction, and any other character that is not a digit is skipped.
// The integer part saturates at 32767 and then raises the overflow flag for
// that text; up to six fraction digits are kept and later ones are dropped.
// The fraction is truncated before the sign is applied, so the result is
// symmetric about zero, and a text with no digits gives zero. Only the beat
// flagged as the last byte produces a result beat, after which the block
// starts afresh on the next text. One input beat is accepted every clock
// cycle unless the result path is full and stalled; the result for a text
// passes through a register after the character accumulator, a register
// after the reciprocal multiply that scales the fraction, and the output
// register. Up to three finished results can be held while the output is
// stalled before the input stops accepting beats.
module decimal_text_to_fixed (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [7:0]                         i_char_byte,
    input  logic                               i_last_byte,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [dtf_pkg::VALUE_W-1:0] o_value_q16,
    output logic                               o_overflow
);
    import dtf_pkg::*;

    // The accumulator and the scaling stage meet at a registered snapshot.
    logic  snap_valid;
    logic  snap_ready;
    t_snap snap;

    dtf_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_char_byte  (i_char_byte),
        .i_last_byte  (i_last_byte),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    // The fraction is normalised to millionths, so one fixed reciprocal
    // multiply gives the truncated 16-bit fraction for any digit count.
    dtf_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_value_q16  (o_value_q16),
        .o_overflow   (o_overflow)
    );

endmodule

// ----- rtl/dtf_accum.sv -----
// Character accumulator: parses one ASCII beat per cycle unless stalled, and
// hands over a snapshot of the number on the last beat. Depends on dtf_pkg.
module dtf_accum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_char_byte,
    input  logic           i_last_byte,
    output logic           o_snap_valid,
    input  logic           i_snap_ready,
    output dtf_pkg::t_snap o_snap
);
    import dtf_pkg::*;

    logic [INT_W-1:0]    r_int_acc, n_int_acc;
    logic [FRAC_W-1:0]   r_frac_acc, n_frac_acc;
    logic [DIGITS_W-1:0] r_frac_digits, n_frac_digits;
    logic                r_minus_seen, n_minus_seen;
    logic                r_point_seen, n_point_seen;
    logic                r_int_saturated, n_int_saturated;
    logic                r_snap_valid;
    t_snap               r_snap;

    logic                accept;
    logic                is_digit;
    logic [3:0]          digit;
    logic [INT_W+3:0]    int_wide;

    assign o_ready = !r_snap_valid || i_snap_ready;
    assign accept  = i_valid && o_ready;

    assign is_digit = (i_char_byte >= CHAR_ZERO) && (i_char_byte <= CHAR_NINE);
    assign digit    = i_char_byte[3:0];
    assign int_wide = (INT_W+4)'(r_int_acc) * (INT_W+4)'(10) + (INT_W+4)'(digit);

    always_comb begin
        n_int_acc       = r_int_acc;
        n_frac_acc      = r_frac_acc;
        n_frac_digits   = r_frac_digits;
        n_minus_seen    = r_minus_seen;
        n_point_seen    = r_point_seen;
        n_int_saturated = r_int_saturated;
        if (i_char_byte == CHAR_MINUS) begin
            n_minus_seen = 1'b1;
        end else if (i_char_byte == CHAR_POINT) begin
            n_point_seen = 1'b1;
        end else if (is_digit) begin
            if (r_point_seen) begin
                if (r_frac_digits < DIGITS_W'(MAX_FRAC_DIGITS)) begin
                    n_frac_acc    = r_frac_acc + FRAC_W'(digit) * frac_weight(r_frac_digits);
                    n_frac_digits = r_frac_digits + DIGITS_W'(1);
                end
            end else if (int_wide > (INT_W+4)'(INT_MAX)) begin
                n_int_acc       = INT_MAX;
                n_int_saturated = 1'b1;
            end else begin
                n_int_acc = int_wide[INT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_acc       <= '0;
            r_frac_acc      <= '0;
            r_frac_digits   <= '0;
            r_minus_seen    <= 1'b0;
            r_point_seen    <= 1'b0;
            r_int_saturated <= 1'b0;
            r_snap_valid    <= 1'b0;
        end else begin
            if (i_snap_ready) begin
                r_snap_valid <= 1'b0;
            end
            if (accept) begin
                if (i_last_byte) begin
                    r_int_acc       <= '0;
                    r_frac_acc      <= '0;
                    r_frac_digits   <= '0;
                    r_minus_seen    <= 1'b0;
                    r_point_seen    <= 1'b0;
                    r_int_saturated <= 1'b0;
                    r_snap_valid    <= 1'b1;
                end else begin
                    r_int_acc       <= n_int_acc;
                    r_frac_acc      <= n_frac_acc;
                    r_frac_digits   <= n_frac_digits;
                    r_minus_seen    <= n_minus_seen;
                    r_point_seen    <= n_point_seen;
                    r_int_saturated <= n_int_saturated;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_snap.int_part  <= n_int_acc;
            r_snap.frac_norm <= n_frac_acc;
            r_snap.minus     <= n_minus_seen;
            r_snap.saturated <= n_int_saturated;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

// ----- rtl/dtf_scale.sv -----
// Fraction scaling and sign stage: turns a snapshot into a Q15.16 result
// through a reciprocal multiply and a registered negate. Depends on dtf_pkg.
module dtf_scale (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_snap_valid,
    output logic                       o_snap_ready,
    input  dtf_pkg::t_snap             i_snap,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [dtf_pkg::VALUE_W-1:0] o_value_q16,
    output logic                       o_overflow
);
    import dtf_pkg::*;

    logic                r_p_valid;
    logic [FRAC_Q_W-1:0] r_p_frac_q;
    logic [INT_W-1:0]    r_p_int;
    logic                r_p_minus;
    logic                r_p_sat;
    logic                r_o_valid;
    logic [VALUE_W-1:0]  r_o_value;
    logic                r_o_ovf;

    logic                p_ready;
    logic                load_p;
    logic                load_o;
    logic [PROD_W-1:0]   prod;
    logic [VALUE_W-1:0]  mag;

    assign p_ready      = !r_o_valid || i_ready;
    assign o_snap_ready = !r_p_valid || p_ready;
    assign load_p       = i_snap_valid && o_snap_ready;
    assign load_o       = r_p_valid && p_ready;

    assign prod = PROD_W'(i_snap.frac_norm) * PROD_W'(RECIP_MULT);
    assign mag  = {1'b0, r_p_int, r_p_frac_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_snap_ready) begin
                r_p_valid <= i_snap_valid;
            end
            if (p_ready) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_p) begin
            r_p_frac_q <= prod[RECIP_SHIFT+FRAC_Q_W-1:RECIP_SHIFT];
            r_p_int    <= i_snap.int_part;
            r_p_minus  <= i_snap.minus;
            r_p_sat    <= i_snap.saturated;
        end
        if (load_o) begin
            r_o_value <= r_p_minus ? (VALUE_W'(0) - mag) : mag;
            r_o_ovf   <= r_p_sat;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_value_q16 = $signed(r_o_value);
    assign o_overflow  = r_o_ovf;

endmodule

// ----- rtl/dtf_checker.sv -----
// Port-level checks for the decimal text to fixed-point converter, with the
// bind that attaches them to the top level. Depends on dtf_pkg.
module dtf_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic signed [dtf_pkg::VALUE_W-1:0] o_value_q16,
    input logic                               o_overflow
);
    import dtf_pkg::*;

    // A result beat that is stalled keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value_q16) && $stable(o_overflow))
        else $error("result beat changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat present after reset");

    // A saturated integer part shows as the largest magnitude in either sign.
    a_ovf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |->
            (o_value_q16[31:16] == 16'h7FFF) || (o_value_q16[31:16] == 16'h8000) ||
            (o_value_q16 == 32'sh8001_0000))
        else $error("overflow flagged on a value below saturation");

    // The magnitude never exceeds 32767 plus a fraction, so the most negative
    // code cannot appear.
    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_value_q16 != 32'sh8000_0000)
        else $error("result outside the representable magnitude");

endmodule

bind decimal_text_to_fixed dtf_checker u_dtf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_value_q16 (o_value_q16),
    .o_overflow  (o_overflow)
);
